[src/mtq_pkg.sv]
// Shared types, sizes and helpers for the min tracking queue.
package mtq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 11;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [CNT_W-1:0]         depth_t;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CLR = 2'd2,
        CMD_QRY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_EXEC,
        S_LOAD,
        S_XFER,
        S_RESP
    } back_state_t;

    typedef struct packed {
        cmd_t  cmd;
        data_t value;
    } op_t;

    // head of the op queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } op_head_t;

    // one stack slot: value and running minimum of it and all below
    typedef struct packed {
        data_t val;
        data_t min;
    } slot_t;

    function automatic data_t smin(input data_t a, input data_t b);
        smin = (a < b) ? a : b;
    endfunction

endpackage

[src/mtq_in_if.sv]
// Request channel: command word with valid/ready handshake.
interface mtq_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    mtq_pkg::data_t      value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

[src/mtq_out_if.sv]
// Response channel: result word with valid/ready handshake.
interface mtq_out_if;
    logic                          valid;
    logic                          ready;
    mtq_pkg::data_t                removed_value;
    mtq_pkg::data_t                front_value;
    mtq_pkg::data_t                min_value;
    logic [mtq_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;
    mtq_pkg::status_t              status;

    modport source (output valid, output removed_value, output front_value,
                    output min_value, output count, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input removed_value, input front_value,
                    input min_value, input count, input is_empty,
                    input status, output ready);
endinterface

[src/mtq_front.sv]
// Front end: accepts request words, decodes them and holds them in a two-entry op queue.
module mtq_front (
    input  logic              clk,
    input  logic              rst_n,
    mtq_in_if.sink            req,
    output mtq_pkg::op_head_t head,
    input  logic              pop
);

    mtq_pkg::op_t  entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          push;
    logic          take;
    mtq_pkg::op_t  op_in;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign take      = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        op_in.cmd   = mtq_pkg::cmd_t'(req.cmd);
        op_in.value = req.value;
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[src/mtq_back.sv]
// Back end: two-stack queue with running minimums, stack memories and the response register.
module mtq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mtq_pkg::op_head_t head,
    output logic              pop,
    mtq_out_if.source         rsp
);

    // in stack only needs values; its top minimum lives in a register
    mtq_pkg::data_t  in_mem  [mtq_pkg::QUEUE_DEPTH];
    mtq_pkg::slot_t  out_mem [mtq_pkg::QUEUE_DEPTH];

    mtq_pkg::back_state_t state_reg, state_next;
    mtq_pkg::depth_t      in_depth_reg, in_depth_next;
    mtq_pkg::depth_t      out_depth_reg, out_depth_next;
    mtq_pkg::data_t       in_top_min_reg, in_top_min_next;
    mtq_pkg::slot_t       out_top_reg, out_top_next;
    mtq_pkg::data_t       removed_reg, removed_next;
    mtq_pkg::status_t     status_reg, status_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    mtq_pkg::data_t       rsp_removed_reg;
    mtq_pkg::data_t       rsp_front_reg;
    mtq_pkg::data_t       rsp_min_reg;
    logic [mtq_pkg::COUNT_W-1:0] rsp_count_reg;
    logic                 rsp_empty_reg;
    mtq_pkg::status_t     rsp_status_reg;
    logic                 rsp_load;

    logic                 in_we, in_re;
    mtq_pkg::ptr_t        in_waddr, in_raddr;
    mtq_pkg::data_t       in_wdata, in_rdata_reg;
    logic                 out_we, out_re;
    mtq_pkg::ptr_t        out_waddr, out_raddr;
    mtq_pkg::slot_t       out_wdata, out_rdata_reg;

    mtq_pkg::depth_t      total;
    mtq_pkg::depth_t      in_m1, in_m2, out_m2;
    mtq_pkg::data_t       new_min;
    mtq_pkg::data_t       xfer_min;
    mtq_pkg::data_t       q_min;

    assign total  = in_depth_reg + out_depth_reg;
    assign in_m1  = in_depth_reg - mtq_pkg::CNT_W'(1);
    assign in_m2  = in_depth_reg - mtq_pkg::CNT_W'(2);
    assign out_m2 = out_depth_reg - mtq_pkg::CNT_W'(2);

    assign new_min  = (in_depth_reg == '0) ? head.op.value
                    : mtq_pkg::smin(in_top_min_reg, head.op.value);
    assign xfer_min = (out_depth_reg == '0) ? in_rdata_reg
                    : mtq_pkg::smin(out_top_reg.min, in_rdata_reg);
    assign q_min    = (in_depth_reg == '0) ? out_top_reg.min
                    : mtq_pkg::smin(out_top_reg.min, in_top_min_reg);

    assign rsp_load = (state_reg == mtq_pkg::S_RESP) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        in_depth_next   = in_depth_reg;
        out_depth_next  = out_depth_reg;
        in_top_min_next = in_top_min_reg;
        out_top_next    = out_top_reg;
        removed_next    = removed_reg;
        status_next     = status_reg;
        pop             = 1'b0;
        in_we           = 1'b0;
        in_waddr        = in_depth_reg[mtq_pkg::PTR_W-1:0];
        in_wdata        = head.op.value;
        in_re           = 1'b0;
        in_raddr        = in_m1[mtq_pkg::PTR_W-1:0];
        out_we          = 1'b0;
        out_waddr       = out_depth_reg[mtq_pkg::PTR_W-1:0];
        out_wdata       = '{val: head.op.value, min: head.op.value};
        out_re          = 1'b0;
        out_raddr       = out_m2[mtq_pkg::PTR_W-1:0];

        case (state_reg)
            mtq_pkg::S_EXEC:
            begin
                if (head.valid)
                begin
                    pop          = 1'b1;
                    removed_next = '0;
                    status_next  = mtq_pkg::STAT_OK;
                    state_next   = mtq_pkg::S_RESP;
                    case (head.op.cmd)
                        mtq_pkg::CMD_ENQ:
                        begin
                            if (total >= mtq_pkg::CNT_W'(mtq_pkg::QUEUE_DEPTH))
                            begin
                                status_next = mtq_pkg::STAT_FULL;
                            end
                            else if (out_depth_reg == '0)
                            begin
                                // empty queue: the value goes straight to the out stack
                                out_we         = 1'b1;
                                out_depth_next = mtq_pkg::CNT_W'(1);
                                out_top_next   = out_wdata;
                            end
                            else
                            begin
                                in_we           = 1'b1;
                                in_depth_next   = in_depth_reg + mtq_pkg::CNT_W'(1);
                                in_top_min_next = new_min;
                            end
                        end
                        mtq_pkg::CMD_DEQ:
                        begin
                            if (total == '0)
                            begin
                                status_next = mtq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                removed_next   = out_top_reg.val;
                                out_depth_next = out_depth_reg - mtq_pkg::CNT_W'(1);
                                if (out_depth_reg >= mtq_pkg::CNT_W'(2))
                                begin
                                    out_re     = 1'b1;
                                    state_next = mtq_pkg::S_LOAD;
                                end
                                else if (in_depth_reg != '0)
                                begin
                                    in_re      = 1'b1;
                                    state_next = mtq_pkg::S_XFER;
                                end
                            end
                        end
                        mtq_pkg::CMD_CLR:
                        begin
                            in_depth_next  = '0;
                            out_depth_next = '0;
                        end
                        mtq_pkg::CMD_QRY:
                        begin
                            if (total == '0)
                            begin
                                status_next = mtq_pkg::STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            status_next = mtq_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            mtq_pkg::S_LOAD:
            begin
                out_top_next = out_rdata_reg;
                state_next   = mtq_pkg::S_RESP;
            end
            mtq_pkg::S_XFER:
            begin
                // one entry per cycle; next read issued alongside this write
                out_we         = 1'b1;
                out_wdata      = '{val: in_rdata_reg, min: xfer_min};
                out_top_next   = out_wdata;
                out_depth_next = out_depth_reg + mtq_pkg::CNT_W'(1);
                in_depth_next  = in_m1;
                if (in_depth_reg >= mtq_pkg::CNT_W'(2))
                begin
                    in_re    = 1'b1;
                    in_raddr = in_m2[mtq_pkg::PTR_W-1:0];
                end
                else
                begin
                    state_next = mtq_pkg::S_RESP;
                end
            end
            mtq_pkg::S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = mtq_pkg::S_EXEC;
                end
            end
            default:
            begin
                state_next = mtq_pkg::S_EXEC;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtq_pkg::S_EXEC;
            in_depth_reg  <= '0;
            out_depth_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_depth_reg  <= in_depth_next;
            out_depth_reg <= out_depth_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_top_min_reg <= in_top_min_next;
        out_top_reg    <= out_top_next;
        removed_reg    <= removed_next;
        status_reg     <= status_next;
        if (rsp_load)
        begin
            rsp_removed_reg <= removed_reg;
            rsp_front_reg   <= (out_depth_reg == '0) ? '0 : out_top_reg.val;
            rsp_min_reg     <= (out_depth_reg == '0) ? '0 : q_min;
            rsp_count_reg   <= mtq_pkg::COUNT_W'(total);
            rsp_empty_reg   <= (total == '0);
            rsp_status_reg  <= status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_waddr] <= in_wdata;
        end
        if (in_re)
        begin
            in_rdata_reg <= in_mem[in_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= out_wdata;
        end
        if (out_re)
        begin
            out_rdata_reg <= out_mem[out_raddr];
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = rsp_removed_reg;
    assign rsp.front_value   = rsp_front_reg;
    assign rsp.min_value     = rsp_min_reg;
    assign rsp.count         = rsp_count_reg;
    assign rsp.is_empty      = rsp_empty_reg;
    assign rsp.status        = rsp_status_reg;

endmodule

[src/min_tracking_queue.sv]
// Top level of the min tracking queue: front end, op queue and two-stack back end.
//
//   channel  direction  payload
//   req      in         cmd, value
//   rsp      out        removed_value, front_value, min_value, count, is_empty, status
//
// Each word passes through the back end's execute and response states once it leaves
// the op queue. A dequeue that exposes a new out-stack top adds a load state (one
// registered read of the out-stack memory). A dequeue that empties the out stack moves
// the in stack over, one entry per cycle through the in-stack memory read port.
// Reset clears the depths and handshake state; the stack memories are not cleared.
// A stalled rsp holds the back end in its response state; req keeps filling the
// two-entry op queue meanwhile.
module min_tracking_queue (
    input  logic      clk,
    input  logic      rst_n,
    mtq_in_if.sink    req,
    mtq_out_if.source rsp
);

    mtq_pkg::op_head_t head;
    logic              pop;

    mtq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    mtq_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

[tb/tb_min_tracking_queue.sv]
// Testbench for min_tracking_queue: random and directed command words checked against a FIFO model.
`timescale 1ns / 1ps

module tb_min_tracking_queue;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MIX_ITEMS   = 440;

    typedef struct {
        mtq_pkg::data_t                removed;
        mtq_pkg::data_t                front;
        mtq_pkg::data_t                smallest;
        logic [mtq_pkg::COUNT_W-1:0]   count;
        logic                          is_empty;
        mtq_pkg::status_t              status;
    } rsp_word_t;

    // Tracks queue contents in arrival order; front and minimum come straight from it.
    class min_queue_scoreboard;
        mtq_pkg::data_t held[$];
        rsp_word_t      expected_rsp[$];
        int             fails;

        function void note_word(mtq_pkg::cmd_t c, mtq_pkg::data_t v);
            rsp_word_t w;
            w.removed  = '0;
            w.front    = '0;
            w.smallest = '0;
            w.status   = mtq_pkg::STAT_OK;
            case (c)
                mtq_pkg::CMD_ENQ:
                    if (held.size() >= mtq_pkg::QUEUE_DEPTH)
                        w.status = mtq_pkg::STAT_FULL;
                    else
                        held.push_back(v);
                mtq_pkg::CMD_DEQ:
                    if (held.size() == 0)
                        w.status = mtq_pkg::STAT_EMPTY;
                    else
                        w.removed = held.pop_front();
                mtq_pkg::CMD_CLR:
                    held.delete();
                default:
                    if (held.size() == 0)
                        w.status = mtq_pkg::STAT_EMPTY;
            endcase
            w.count    = mtq_pkg::COUNT_W'(held.size());
            w.is_empty = (held.size() == 0);
            if (held.size() != 0)
            begin
                w.front    = held[0];
                w.smallest = held[0];
                foreach (held[i])
                    if (held[i] < w.smallest)
                        w.smallest = held[i];
            end
            expected_rsp.push_back(w);
        endfunction

        function void cmp_field(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, field, want, got);
                fails++;
            end
        endfunction

        function void check_word(rsp_word_t got);
            rsp_word_t want;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: response word with nothing outstanding", $time);
                fails++;
                return;
            end
            want = expected_rsp.pop_front();
            cmp_field("removed_value", want.removed, got.removed);
            cmp_field("front_value", want.front, got.front);
            cmp_field("min_value", want.smallest, got.smallest);
            cmp_field("count", want.count, got.count);
            cmp_field("is_empty", want.is_empty, got.is_empty);
            cmp_field("status", want.status, got.status);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    min_queue_scoreboard sb = new();

    mtq_in_if  req();
    mtq_out_if rsp();

    min_tracking_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // response side: check on accept, then decide ready for the next cycle
    always @(posedge clk)
    begin : rsp_side
        rsp_word_t got;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.removed  = rsp.removed_value;
                got.front    = rsp.front_value;
                got.smallest = rsp.min_value;
                got.count    = rsp.count;
                got.is_empty = rsp.is_empty;
                got.status   = rsp.status;
                sb.check_word(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    rsp.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic mtq_pkg::data_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(mtq_pkg::cmd_t c, mtq_pkg::data_t v);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= c;
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_word(c, v);
    endtask

    task automatic send_mixed();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            send_word(mtq_pkg::CMD_ENQ, pick_value());
        else if (pick < 8)
            send_word(mtq_pkg::CMD_DEQ, pick_value());
        else
            send_word(mtq_pkg::CMD_QRY, pick_value());
    endtask

    // hold off new words until every outstanding response is back
    task automatic wait_for_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // runs of enqueues, dequeues and mixed words, with single clears and queries, so both stacks fill, drain and swap
    task automatic mix_phase(int n_items);
        int sent;
        int run;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            run  = $urandom_range(1, 20);
            if (kind < 4)
                repeat (run) send_word(mtq_pkg::CMD_ENQ, pick_value());
            else if (kind < 7)
                repeat (run) send_word(mtq_pkg::CMD_DEQ, pick_value());
            else if (kind < 9)
                repeat (run) send_mixed();
            else if ($urandom_range(0, 2) == 0)
            begin
                run = 1;
                send_word(mtq_pkg::CMD_CLR, pick_value());
            end
            else
            begin
                run = 1;
                send_word(mtq_pkg::CMD_QRY, pick_value());
            end
            sent += run;
        end
    endtask

    task automatic fill_phase();
        send_word(mtq_pkg::CMD_CLR, 32'hffff_ffff);
        repeat (mtq_pkg::QUEUE_DEPTH) send_word(mtq_pkg::CMD_ENQ, pick_value());
        // full: these are dropped
        repeat (3) send_word(mtq_pkg::CMD_ENQ, pick_value());
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_ENQ, 32'h8000_0000);
        send_word(mtq_pkg::CMD_ENQ, 32'h7fff_ffff);
        quiet = 1'b1;
        repeat (40) send_word(mtq_pkg::CMD_DEQ, pick_value());
        repeat (10) send_word(mtq_pkg::CMD_ENQ, pick_value());
        repeat (20) send_mixed();
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        send_word(mtq_pkg::CMD_CLR, 32'h0);
        send_word(mtq_pkg::CMD_QRY, 32'h0);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.cmd   <= mtq_pkg::CMD_QRY;
        req.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty-queue cases, extremes, and a min that lives in the in stack
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h5555_5555);
        send_word(mtq_pkg::CMD_CLR, 32'haaaa_aaaa);
        send_word(mtq_pkg::CMD_ENQ, 32'h7fff_ffff);
        send_word(mtq_pkg::CMD_ENQ, 32'h8000_0000);
        send_word(mtq_pkg::CMD_ENQ, 32'h0);
        send_word(mtq_pkg::CMD_ENQ, 32'hffff_ffff);
        send_word(mtq_pkg::CMD_ENQ, 32'h1);
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_ENQ, 32'h5);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        send_word(mtq_pkg::CMD_CLR, 32'h0);
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_ENQ, -32'sd5);
        send_word(mtq_pkg::CMD_ENQ, -32'sd5);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_DEQ, 32'h0);
        send_word(mtq_pkg::CMD_QRY, 32'h0);
        wait_for_results();

        mix_phase(MIX_ITEMS);
        wait_for_results();

        fill_phase();

        req.valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.fails == 0 && sb.expected_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/mtq_pkg.sv
src/mtq_in_if.sv
src/mtq_out_if.sv
src/mtq_front.sv
src/mtq_back.sv
src/min_tracking_queue.sv
tb/tb_min_tracking_queue.sv
